@@ rtl/cpaf_pkg.sv @@
// Shared types and codes for the CIDR and port access filter.
package cpaf_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_ALLOW = 3'd0,
    REQ_ADD_DENY  = 3'd1,
    REQ_ADD_PORT  = 3'd2,
    REQ_CONNECT   = 3'd3,
    REQ_BIND      = 3'd4,
    REQ_CLEAR     = 3'd5,
    REQ_RSVD6     = 3'd6,
    REQ_RSVD7     = 3'd7
  } req_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DENIED    = 3'd1;
  localparam logic [2:0] ST_PORT      = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOW = 3'd3;
  localparam logic [2:0] ST_DEF_DENY  = 3'd4;
  localparam logic [2:0] ST_BAD_PFX   = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  // Lookup key that travels down the rule chains.
  typedef struct packed {
    logic        is_ipv6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [7:0]  proto;
  } key_t;

  // Write command broadcast to one chain.
  typedef struct packed {
    logic        wr;
    logic        clr;
    logic        is_ipv6;
    logic [63:0] net_hi;
    logic [63:0] net_lo;
    logic [7:0]  prefix;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [7:0]  proto;
  } rule_wr_t;

  // Prefix mask over a 128-bit address; IPv4 lives in bits 31..0.
  function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] p);
    logic [127:0] m;
    m = '0;
    if (v6) begin
      if (p != 8'd0) m = ~(128'h0) << (8'd128 - p);
    end else begin
      if (p != 8'd0) m = {96'h0, ~(32'h0) << (6'd32 - p[5:0])};
    end
    return m;
  endfunction

endpackage

@@ rtl/cpaf_cell.sv @@
// One rule cell: a range or port rule, ORs its match into the hit passed along.
module cpaf_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                is_range,
  input  logic                sel,
  input  cpaf_pkg::rule_wr_t  wr_cmd,
  input  cpaf_pkg::key_t      key_in,
  input  logic                hit_in,
  output cpaf_pkg::key_t      key_out,
  output logic                hit_out
);
  import cpaf_pkg::*;

  logic         valid;
  logic         v6;
  logic [7:0]   prefix;
  logic [127:0] net;
  logic [15:0]  plo, phi;
  logic [7:0]   pm;
  logic [127:0] mask;
  logic [127:0] addr;
  logic         match;

  always_ff @(posedge clk) begin
    if (rst || wr_cmd.clr) begin
      valid <= 1'b0;
    end else if (wr_cmd.wr && sel) begin
      valid <= 1'b1;
    end
    if (wr_cmd.wr && sel) begin
      v6     <= wr_cmd.is_ipv6;
      prefix <= wr_cmd.prefix;
      net    <= {wr_cmd.net_hi, wr_cmd.net_lo};
      plo    <= wr_cmd.port_low;
      phi    <= wr_cmd.port_high;
      pm     <= wr_cmd.proto;
    end
  end

  always_comb begin
    mask = prefix_mask(v6, prefix);
    addr = {key_in.addr_hi, key_in.addr_lo};
    if (is_range) begin
      match = valid && (v6 == key_in.is_ipv6) && ((addr & mask) == net);
    end else begin
      match = valid && (key_in.port >= plo) && (key_in.port <= phi) &&
              ((pm & key_in.proto) != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    key_out <= key_in;
    hit_out <= hit_in | match;
  end
endmodule

@@ rtl/cpaf_chain.sv @@
// Row of rule cells with a fill count; a lookup walks one cell per cycle.
module cpaf_chain #(
  parameter int ENTRIES = 16,
  parameter bit IS_RANGE = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  cpaf_pkg::rule_wr_t  wr_cmd,
  input  cpaf_pkg::key_t      key,
  output logic                hit,
  output logic [$clog2(ENTRIES+1)-1:0] count
);
  import cpaf_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  key_t keys [ENTRIES+1];
  logic hits [ENTRIES+1];

  assign keys[0] = key;
  assign hits[0] = 1'b0;
  assign hit     = hits[ENTRIES];

  always_ff @(posedge clk) begin
    if (rst || wr_cmd.clr) begin
      count <= '0;
    end else if (wr_cmd.wr) begin
      count <= count + CW'(1);
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cpaf_cell u_cell (
      .clk(clk), .rst(rst), .is_range(IS_RANGE),
      .sel(count == CW'(i)), .wr_cmd(wr_cmd),
      .key_in(keys[i]), .hit_in(hits[i]),
      .key_out(keys[i+1]), .hit_out(hits[i+1])
    );
  end
endmodule

@@ rtl/cidr_port_access_filter_unit.sv @@
// Top level of the CIDR and port access filter.
// Usage:
//  - in_valid/in_ready carry one request transaction: req_type, address,
//    prefix, port range and protocol mask. out_valid/out_ready carry one
//    result transaction per request: permit and status.
//  - cfg_valid/cfg_ready writes the default policy bit (cfg_data, 1 allows);
//    write it only while no request is in flight.
//  - Rule adds and clear are answered without walking the chains. A connect
//    or bind check walks the three rule chains, one cell per cycle; the
//    chain length sets how long it takes.
//  - One request is in flight at a time: in_ready is low from accept until
//    the result transaction is taken.
//  - Reset empties all tables and selects default deny.
//  - A stalled receiver holds the result; in_ready stays low until it is taken.
module cidr_port_access_filter_unit #(
  parameter int RANGE_ENTRIES = 16,
  parameter int PORT_ENTRIES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic        is_ipv6,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  cidr_len,
  input  logic [15:0] port_low,
  input  logic [15:0] port_high,
  input  logic [7:0]  proto_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        permit,
  output logic [2:0]  status
);
  import cpaf_pkg::*;

  localparam int RCW = $clog2(RANGE_ENTRIES + 1);
  localparam int PCW = $clog2(PORT_ENTRIES + 1);
  localparam int DEPTH = (RANGE_ENTRIES > PORT_ENTRIES) ? RANGE_ENTRIES : PORT_ENTRIES;
  localparam int WW = $clog2(DEPTH + 1);

  typedef enum logic [0:0] {S_IDLE, S_WALK} state_t;

  state_t      state;
  logic [WW-1:0] wait_cnt;
  logic        open_policy;
  logic        chk_bind;
  logic [15:0] chk_port;
  logic [RCW-1:0] allow_snap;

  key_t        key;
  rule_wr_t    wr_allow, wr_deny, wr_port, wr_base;
  logic        hit_allow, hit_deny, hit_port;
  logic [RCW-1:0] allow_count, deny_count;
  logic [PCW-1:0] port_count;
  logic        accept;
  logic [127:0] mask;
  logic        pfx_bad;
  logic        res_permit;
  logic [2:0]  res_status;
  logic        load_imm;
  logic        imm_permit;
  logic [2:0]  imm_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_policy <= 1'b0;
    end else if (cfg_valid) begin
      open_policy <= cfg_data;
    end
  end

  always_comb begin
    mask    = prefix_mask(is_ipv6, cidr_len);
    pfx_bad = cidr_len > (is_ipv6 ? 8'd128 : 8'd32);
    key     = '{is_ipv6: is_ipv6, addr_hi: addr_hi, addr_lo: addr_lo,
                port: port_low, proto: proto_mask};
    wr_base = '{wr: 1'b0, clr: 1'b0, is_ipv6: is_ipv6,
                net_hi: is_ipv6 ? (addr_hi & mask[127:64]) : 64'h0,
                net_lo: addr_lo & mask[63:0], prefix: cidr_len,
                port_low: port_low, port_high: port_high, proto: proto_mask};
    wr_allow = wr_base;
    wr_deny  = wr_base;
    wr_port  = wr_base;
    load_imm   = 1'b0;
    imm_permit = 1'b0;
    imm_status = ST_OK;
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_ADD_ALLOW, REQ_ADD_DENY: begin
          load_imm = 1'b1;
          if (pfx_bad) begin
            imm_status = ST_BAD_PFX;
          end else if ((req_type == REQ_ADD_ALLOW)
                       ? (allow_count == RCW'(RANGE_ENTRIES))
                       : (deny_count == RCW'(RANGE_ENTRIES))) begin
            imm_status = ST_FULL;
          end else begin
            imm_permit = 1'b1;
            if (req_type == REQ_ADD_ALLOW) wr_allow.wr = 1'b1;
            else                           wr_deny.wr  = 1'b1;
          end
        end
        REQ_ADD_PORT: begin
          load_imm = 1'b1;
          if (port_count == PCW'(PORT_ENTRIES)) begin
            imm_status = ST_FULL;
          end else begin
            imm_permit = 1'b1;
            wr_port.wr = 1'b1;
          end
        end
        REQ_CLEAR: begin
          load_imm   = 1'b1;
          imm_permit = 1'b1;
          wr_allow.clr = 1'b1;
          wr_deny.clr  = 1'b1;
          wr_port.clr  = 1'b1;
        end
        REQ_CONNECT, REQ_BIND: ;
        REQ_RSVD6, REQ_RSVD7: load_imm = 1'b1;
        default: load_imm = 1'b1;
      endcase
    end
  end

  cpaf_chain #(.ENTRIES(RANGE_ENTRIES), .IS_RANGE(1'b1)) u_allow (
    .clk(clk), .rst(rst), .wr_cmd(wr_allow), .key(key),
    .hit(hit_allow), .count(allow_count));
  cpaf_chain #(.ENTRIES(RANGE_ENTRIES), .IS_RANGE(1'b1)) u_deny (
    .clk(clk), .rst(rst), .wr_cmd(wr_deny), .key(key),
    .hit(hit_deny), .count(deny_count));
  cpaf_chain #(.ENTRIES(PORT_ENTRIES), .IS_RANGE(1'b0)) u_port (
    .clk(clk), .rst(rst), .wr_cmd(wr_port), .key(key),
    .hit(hit_port), .count(port_count));

  // Deny and allow hits are captured when the walk reaches the last range cell, the port hit at the last port cell.
  logic hd, hp, ha;
  logic [WW-1:0] elapsed;
  always_ff @(posedge clk) begin
    if (state == S_WALK) begin
      if (elapsed == WW'(RANGE_ENTRIES - 1)) begin
        hd <= hit_deny;
        ha <= hit_allow;
      end
      if (elapsed == WW'(PORT_ENTRIES - 1)) hp <= hit_port;
    end
  end

  always_comb begin
    res_permit = 1'b0;
    res_status = ST_OK;
    priority if (hd) begin
      res_status = ST_DENIED;
    end else if (chk_port != 16'd0 && port_count != '0 && !hp) begin
      res_status = ST_PORT;
    end else if (!chk_bind && allow_snap != '0 && !ha) begin
      res_status = ST_NOT_ALLOW;
    end else if (!chk_bind && allow_snap == '0 && !open_policy) begin
      res_status = ST_DEF_DENY;
    end else begin
      res_permit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      elapsed   <= '0;
      wait_cnt  <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (load_imm) begin
              out_valid <= 1'b1;
              permit    <= imm_permit;
              status    <= imm_status;
            end else begin
              state      <= S_WALK;
              elapsed    <= '0;
              wait_cnt   <= WW'(DEPTH);
              chk_bind   <= (req_type == REQ_BIND);
              chk_port   <= port_low;
              allow_snap <= allow_count;
            end
          end
        end
        S_WALK: begin
          elapsed <= elapsed + WW'(1);
          if (wait_cnt == '0) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            permit    <= res_permit;
            status    <= res_status;
          end else begin
            wait_cnt <= wait_cnt - WW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
